// ===== rtl/sorted_priority_queue_unit_defines.svh =====
// Assertion macros, clocked on clk with the asynchronous reset rst_n.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int PRIO_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                 enq;
        logic                 deq;
        logic [PRIO_BITS-1:0] prio;
    } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
    input  logic                             clk,
    input  spq_pkg::cell_ctrl_t              ctl,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0] new_payload,
    input  logic                             occupied,
    input  logic                             left_ge,
    input  logic [spq_pkg::PRIO_BITS-1:0]    left_prio,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0] left_payload,
    input  logic [spq_pkg::PRIO_BITS-1:0]    right_prio,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0] right_payload,
    output logic                             ge,
    output logic [spq_pkg::PRIO_BITS-1:0]    prio,
    output logic [spq_pkg::PAYLOAD_BITS-1:0] payload_out
);

    logic [spq_pkg::PRIO_BITS-1:0]    prio_reg;
    logic [spq_pkg::PRIO_BITS-1:0]    prio_next;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload_reg;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload_next;

    // entry stays ahead of the new one
    assign ge = occupied && (prio_reg >= ctl.prio);

    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctl.enq)
        begin
            if (!ge)
            begin
                if (left_ge)
                begin
                    // first cell past the equal-or-higher run takes the new word
                    prio_next    = ctl.prio;
                    payload_next = new_payload;
                end
                else
                begin
                    prio_next    = left_prio;
                    payload_next = left_payload;
                end
            end
        end
        else if (ctl.deq)
        begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio        = prio_reg;
    assign payload_out = payload_reg;

endmodule

// ===== rtl/sorted_priority_queue_unit.sv =====
// Sorted priority queue of spq_pkg::QUEUE_DEPTH entries held in a row of cells, head in
// cell 0. Every cell compares its priority with the incoming one in parallel and either
// holds, takes the new word, or shifts from its neighbour, so one word is taken every
// cycle while in_stall is low and its result is registered in the output register;
// in_stall is high only while that register holds a result the consumer has not taken.
// Equal priorities leave in arrival order. A refused enqueue (full) or dequeue (empty)
// leaves the queue as it was and reports the status with the unchanged count.
module sorted_priority_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [spq_pkg::PRIO_BITS-1:0]      priority_req,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]   payload,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [spq_pkg::STATUS_BITS-1:0]    status,
    output logic [spq_pkg::PAYLOAD_BITS-1:0]   head_payload,
    output logic [spq_pkg::PRIO_BITS-1:0]      head_priority,
    output logic [spq_pkg::POS_BITS-1:0]       insert_position,
    output logic [spq_pkg::COUNT_BITS-1:0]     entry_count
);

`include "sorted_priority_queue_unit_defines.svh"

    localparam int D = spq_pkg::QUEUE_DEPTH;

    logic [spq_pkg::COUNT_BITS-1:0]  count_reg;
    logic [spq_pkg::COUNT_BITS-1:0]  count_next;
    logic [spq_pkg::COUNT_BITS-1:0]  count_inc;
    logic                            out_valid_reg;
    logic [spq_pkg::STATUS_BITS-1:0] status_reg;
    logic [spq_pkg::PAYLOAD_BITS-1:0] head_payload_reg;
    logic [spq_pkg::PRIO_BITS-1:0]   head_priority_reg;
    logic [spq_pkg::POS_BITS-1:0]    insert_position_reg;
    logic [spq_pkg::COUNT_BITS-1:0]  entry_count_reg;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 do_enq;
    logic                 do_deq;
    logic                 enq_full;
    spq_pkg::cell_ctrl_t  ctl;

    logic [D-1:0]                              occ;
    logic [D-1:0]                              ge_vec;
    logic [D-1:0]                              left_ge;
    logic [D-1:0]                              first_free;
    logic [D-1:0][spq_pkg::PRIO_BITS-1:0]      cell_prio;
    logic [D-1:0][spq_pkg::PAYLOAD_BITS-1:0]   cell_payload;
    logic [spq_pkg::POS_BITS-1:0]              pos;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == spq_pkg::COUNT_BITS'(D));
    assign empty    = (count_reg == '0);
    assign do_enq   = accept && (action == spq_pkg::ACT_ENQ) && !full;
    assign do_deq   = accept && (action == spq_pkg::ACT_DEQ) && !empty;
    assign enq_full = accept && (action == spq_pkg::ACT_ENQ) && full;

    assign ctl.enq  = do_enq;
    assign ctl.deq  = do_deq;
    assign ctl.prio = priority_req;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            assign occ[gi] = (spq_pkg::COUNT_BITS'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_ge[gi] = 1'b1;
            end
            else
            begin : g_body
                assign left_ge[gi] = ge_vec[gi-1];
            end

            spq_cell u_cell (
                .clk           (clk),
                .ctl           (ctl),
                .new_payload   (payload),
                .occupied      (occ[gi]),
                .left_ge       (left_ge[gi]),
                .left_prio     ((gi == 0) ? '0 : cell_prio[(gi == 0) ? 0 : gi-1]),
                .left_payload  ((gi == 0) ? '0 : cell_payload[(gi == 0) ? 0 : gi-1]),
                .right_prio    ((gi == D-1) ? '0 : cell_prio[(gi == D-1) ? gi : gi+1]),
                .right_payload ((gi == D-1) ? '0 : cell_payload[(gi == D-1) ? gi : gi+1]),
                .ge            (ge_vec[gi]),
                .prio          (cell_prio[gi]),
                .payload_out   (cell_payload[gi])
            );
        end
    endgenerate

    assign first_free = left_ge & ~ge_vec;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < D; i++)
        begin
            pos = pos | (first_free[i] ? spq_pkg::POS_BITS'(i) : '0);
        end
    end

    assign count_inc = count_reg + spq_pkg::COUNT_BITS'(1);

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_inc;
        end
        else if (do_deq)
        begin
            count_next = count_reg - spq_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg          <= spq_pkg::ST_DONE;
            head_payload_reg    <= '0;
            head_priority_reg   <= '0;
            insert_position_reg <= '0;
            entry_count_reg     <= count_next;
            if (action == spq_pkg::ACT_ENQ)
            begin
                if (full)
                begin
                    status_reg <= spq_pkg::ST_FULL;
                end
                else
                begin
                    insert_position_reg <= pos;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_reg <= spq_pkg::ST_EMPTY;
                end
                else
                begin
                    head_payload_reg  <= cell_payload[0];
                    head_priority_reg <= cell_prio[0];
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign head_payload    = head_payload_reg;
    assign head_priority   = head_priority_reg;
    assign insert_position = insert_position_reg;
    assign entry_count     = entry_count_reg;

    `SPQ_ASSERT(a_count_range, count_reg <= spq_pkg::COUNT_BITS'(D), "count past depth")
    `SPQ_ASSERT(a_sorted_prefix, (ge_vec & ~left_ge) == '0, "stored entries out of order")
    `SPQ_ASSERT(a_one_slot, $onehot0(first_free), "more than one insert slot")
    `SPQ_ASSERT(a_enq_count, do_enq |=> count_reg == $past(count_inc), "enqueue count")
    `SPQ_ASSERT(a_full_status, enq_full |=> out_valid_reg && status_reg == spq_pkg::ST_FULL, "full")

endmodule

// ===== tb/tb_sorted_priority_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_sorted_priority_queue_unit;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic                             action;
        logic [spq_pkg::PRIO_BITS-1:0]    prio;
        logic [spq_pkg::PAYLOAD_BITS-1:0] data;
    } request_t;

    typedef struct packed {
        logic [spq_pkg::STATUS_BITS-1:0]  status;
        logic [spq_pkg::PAYLOAD_BITS-1:0] head_data;
        logic [spq_pkg::PRIO_BITS-1:0]    head_prio;
        logic [spq_pkg::POS_BITS-1:0]     position;
        logic [spq_pkg::COUNT_BITS-1:0]   count;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             action = spq_pkg::ACT_ENQ;
    logic [spq_pkg::PRIO_BITS-1:0]    priority_req = '0;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [spq_pkg::STATUS_BITS-1:0]  status;
    logic [spq_pkg::PAYLOAD_BITS-1:0] head_payload;
    logic [spq_pkg::PRIO_BITS-1:0]    head_priority;
    logic [spq_pkg::POS_BITS-1:0]     insert_position;
    logic [spq_pkg::COUNT_BITS-1:0]   entry_count;

    // shadow copy of the sorted row
    logic [spq_pkg::PRIO_BITS-1:0]    shadow_prio [spq_pkg::QUEUE_DEPTH];
    logic [spq_pkg::PAYLOAD_BITS-1:0] shadow_data [spq_pkg::QUEUE_DEPTH];
    int                               shadow_count = 0;

    request_t req_q [$];
    request_t on_bus;
    result_t  due_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    sorted_priority_queue_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .priority_req    (priority_req),
        .payload         (payload),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .head_payload    (head_payload),
        .head_priority   (head_priority),
        .insert_position (insert_position),
        .entry_count     (entry_count)
    );

    function automatic result_t queue_step(request_t r);
        result_t res;
        int pos;
        int i;
        res = '0;
        res.status = spq_pkg::ST_DONE;
        if (r.action == spq_pkg::ACT_ENQ)
        begin
            if (shadow_count >= spq_pkg::QUEUE_DEPTH)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // new word goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= r.prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_prio[pos] = r.prio;
                shadow_data[pos] = r.data;
                shadow_count++;
                res.position = pos[spq_pkg::POS_BITS-1:0];
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                res.head_data = shadow_data[0];
                res.head_prio = shadow_prio[0];
                for (i = 1; i < shadow_count; i++)
                begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_data[i-1] = shadow_data[i];
                end
                shadow_count--;
            end
        end
        res.count = shadow_count[spq_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    task automatic add_req(logic act, logic [spq_pkg::PRIO_BITS-1:0] p,
                           logic [spq_pkg::PAYLOAD_BITS-1:0] d);
        request_t r;
        r.action = act;
        r.prio = p;
        r.data = d;
        req_q.push_back(r);
    endtask

    // bursts that lean towards filling or draining, so full and empty are hit often
    task automatic add_random(int n);
        int burst_left;
        int enq_pct;
        int prio_lo;
        int prio_hi;
        int k;
        logic [spq_pkg::PRIO_BITS-1:0]    p;
        logic [spq_pkg::PAYLOAD_BITS-1:0] d;
        burst_left = 0;
        enq_pct = 50;
        prio_lo = 0;
        prio_hi = 4;
        for (k = 0; k < n; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = int'($urandom_range(40, 8));
                case ($urandom_range(3))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    2: enq_pct = 55;
                    default: enq_pct = 45;
                endcase
                // narrow priority band now and then to pile up ties
                if ($urandom_range(2) == 0)
                begin
                    prio_lo = int'($urandom_range(4));
                    prio_hi = prio_lo + int'($urandom_range(1));
                end
                else
                begin
                    prio_lo = 0;
                    prio_hi = 4;
                end
            end
            burst_left--;
            if ($urandom_range(99) < 8)
                p = spq_pkg::PRIO_BITS'($urandom_range(7, 5));
            else
                p = spq_pkg::PRIO_BITS'($urandom_range(prio_hi, prio_lo));
            case ($urandom_range(19))
                0: d = '0;
                1: d = '1;
                2: d = spq_pkg::PAYLOAD_BITS'(1) << $urandom_range(spq_pkg::PAYLOAD_BITS-1);
                default: d = spq_pkg::PAYLOAD_BITS'($urandom);
            endcase
            add_req(($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ, p, d);
        end
    endtask

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            action       <= spq_pkg::ACT_ENQ;
            priority_req <= '0;
            payload      <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(queue_step(on_bus));
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = req_q.pop_front();
                    in_valid     <= 1'b1;
                    action       <= on_bus.action;
                    priority_req <= on_bus.prio;
                    payload      <= on_bus.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, status %0d count %0d",
                             $time, status, entry_count);
                end
                else
                begin
                    result_t want;
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report("status", 64'(want.status), 64'(status));
                    if (head_payload !== want.head_data)
                        report("head_payload", 64'(want.head_data), 64'(head_payload));
                    if (head_priority !== want.head_prio)
                        report("head_priority", 64'(want.head_prio), 64'(head_priority));
                    if (insert_position !== want.position)
                        report("insert_position", 64'(want.position), 64'(insert_position));
                    if (entry_count !== want.count)
                        report("entry_count", 64'(want.count), 64'(entry_count));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++)
        begin
            shadow_prio[i] = '0;
            shadow_data[i] = '0;
        end

        // directed: empty dequeue, ties, priorities above four, fill, full, drain
        add_req(spq_pkg::ACT_DEQ, 3'd0, 32'h0000_0000);
        add_req(spq_pkg::ACT_ENQ, 3'd0, 32'h0000_0000);
        add_req(spq_pkg::ACT_ENQ, 3'd4, 32'hFFFF_FFFF);
        add_req(spq_pkg::ACT_ENQ, 3'd4, 32'h0000_0001);
        add_req(spq_pkg::ACT_ENQ, 3'd2, 32'h8000_0000);
        add_req(spq_pkg::ACT_ENQ, 3'd7, 32'h7FFF_FFFF);
        add_req(spq_pkg::ACT_ENQ, 3'd0, 32'hDEAD_BEEF);
        add_req(spq_pkg::ACT_ENQ, 3'd5, 32'h5A5A_5A5A);
        add_req(spq_pkg::ACT_ENQ, 3'd6, 32'hA5A5_A5A5);
        add_req(spq_pkg::ACT_ENQ, 3'd1, 32'h0000_FFFF);
        add_req(spq_pkg::ACT_ENQ, 3'd3, 32'hFFFF_0000);
        add_req(spq_pkg::ACT_ENQ, 3'd4, 32'h1234_5678);
        add_req(spq_pkg::ACT_ENQ, 3'd2, 32'h8765_4321);
        add_req(spq_pkg::ACT_ENQ, 3'd0, 32'h0F0F_0F0F);
        add_req(spq_pkg::ACT_ENQ, 3'd1, 32'hF0F0_F0F0);
        add_req(spq_pkg::ACT_ENQ, 3'd3, 32'h3333_3333);
        add_req(spq_pkg::ACT_ENQ, 3'd4, 32'hCCCC_CCCC);
        add_req(spq_pkg::ACT_ENQ, 3'd4, 32'h9999_9999);
        repeat (6) add_req(spq_pkg::ACT_DEQ, 3'd7, 32'hFFFF_FFFF);

        send_idle_pct = 16;
        recv_idle_pct = 55;
        add_random(640);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_q.size() != 0)
            @(posedge clk);
        send_idle_pct = 55;
        recv_idle_pct = 16;
        add_random(640);

        while (req_q.size() != 0)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(620);

        while (req_q.size() != 0 || in_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_unit.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/tb_sorted_priority_queue_unit.sv
